FILE: hw/rtl/bresenham_line_window_filter_defines.svh
// ---------------------------------------------------------------------------
// Bresenham line window filter: assertion macros
// Shared property forms for the line walker checks. The module that uses
// them provides clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_WINDOW_FILTER_DEFINES_SVH
`define BRESENHAM_LINE_WINDOW_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BLWF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BLWF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/blwf_pkg.sv
// ---------------------------------------------------------------------------
// blwf_pkg
// Types, constants and codes shared by the line window filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package blwf_pkg;

	localparam int COORD_BITS      = 16;
	localparam int MARGIN_BITS     = 8;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int MAX_POINTS_DEF  = 64;

	localparam logic [MARGIN_BITS-1:0] MARGIN_LOW_RST  = 8'd8;
	localparam logic [MARGIN_BITS-1:0] MARGIN_HIGH_RST = 8'd24;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MARGIN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MARGIN_HIGH = 2'd1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] window_x;
		logic signed [COORD_BITS-1:0] window_y;
	} req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         inside_res;
		logic                         last;
		logic                         too_long;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch request
		logic setup;    // deltas, step directions, window bounds
		logic check;    // span test, error seed, start point
		logic emit;     // load output register, advance one point
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic too_long;
		logic at_end;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SETUP = 4'b0010,
		S_CHECK = 4'b0100,
		S_WALK  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bresenham_line_window_filter.sv
// After a request transfer the setup and check states run, then the walk state loads the
//   output register with one point per cycle while the output is not stalled, stepped by
//   the single Bresenham error stepper. A too-long request gives one too-long result.
// A new request is taken once the last point has entered the output register.
// Reset (arst_n, asynchronous, active low): idle, output empty, margins 8 and 24.
// ---------------------------------------------------------------------------
// bresenham_line_window_filter
// Walks a line between two points and tags each point with a window test.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_window_filter_defines.svh"

module bresenham_line_window_filter #(
	parameter int MAX_POINTS = blwf_pkg::MAX_POINTS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  blwf_pkg::req_t                     in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output blwf_pkg::res_t                     out_data,
	input  wire                                cfg_we,
	input  wire [blwf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [blwf_pkg::MARGIN_BITS-1:0]    cfg_data
);
	import blwf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	blwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	blwf_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// a request transfer makes the block busy for the setup cycles
	`BLWF_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held off")
	// the too-long result is always the only and final one
	`BLWF_ASSERT_IMP(a_too_long_last, out_valid && out_data.too_long, out_data.last, "too-long not last")
	`BLWF_ASSERT_IMP(a_too_long_blank, out_valid && out_data.too_long,
		!out_data.inside_res && (out_data.point_x == '0) && (out_data.point_y == '0),
		"too-long result carries a point")
	// every point the controller emits is presented on the output
	`BLWF_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid, "emitted point not presented")

endmodule

`default_nettype wire

FILE: hw/rtl/blwf_ctrl.sv
// ---------------------------------------------------------------------------
// blwf_ctrl
// Sequencer for one line request and owner of the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module blwf_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	output blwf_pkg::cmd_t   cmd,
	input  blwf_pkg::sts_t   sts
);
	import blwf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   emit;
	logic   final_pt;

	assign emit     = (state_q == S_WALK) && (!out_valid_q || !out_stall);
	assign final_pt = sts.too_long || sts.at_end;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.setup   = (state_q == S_SETUP);
		cmd.check   = (state_q == S_CHECK);
		cmd.emit    = emit;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_SETUP;
			S_SETUP: state_d = S_CHECK;
			S_CHECK: state_d = S_WALK;
			S_WALK:  if (emit && final_pt) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/blwf_dpath.sv
// ---------------------------------------------------------------------------
// blwf_dpath
// Line walker datapath: request latch, Bresenham error stepper, window
// bounds, margin registers and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module blwf_dpath #(
	parameter int MAX_POINTS = blwf_pkg::MAX_POINTS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  blwf_pkg::cmd_t                        cmd,
	output blwf_pkg::sts_t                        sts,
	input  blwf_pkg::req_t                        in_data,
	output blwf_pkg::res_t                        out_data,
	input  wire                                   cfg_we,
	input  wire [blwf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire [blwf_pkg::MARGIN_BITS-1:0]       cfg_data
);
	import blwf_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int BW = COORD_BITS + 2;   // bounds and error width
	localparam int EW = COORD_BITS + 3;   // doubled error
	localparam logic [C-1:0] SPAN_MAX = C'(MAX_POINTS - 1);

	logic [MARGIN_BITS-1:0] margin_low_q;
	logic [MARGIN_BITS-1:0] margin_high_q;

	req_t                   req_q;
	logic [C-1:0]           dx_q;
	logic [C-1:0]           dy_q;
	logic                   xneg_q;
	logic                   yneg_q;
	logic signed [BW-1:0]   lo_x_q;
	logic signed [BW-1:0]   hi_x_q;
	logic signed [BW-1:0]   lo_y_q;
	logic signed [BW-1:0]   hi_y_q;
	logic                   too_long_q;
	logic signed [BW-1:0]   err_q;
	logic signed [BW-1:0]   ndy_q;
	logic signed [C-1:0]    cur_x_q;
	logic signed [C-1:0]    cur_y_q;
	res_t                   res_q;

	// setup
	logic signed [C:0]      diff_x;
	logic signed [C:0]      diff_y;
	logic signed [C:0]      adx;
	logic signed [C:0]      ady;
	logic signed [BW-1:0]   wx_e;
	logic signed [BW-1:0]   wy_e;
	logic signed [BW-1:0]   ml_e;
	logic signed [BW-1:0]   mh_e;

	// check
	logic [C-1:0]           span;
	logic signed [BW-1:0]   dx_e;
	logic signed [BW-1:0]   dy_e;

	// walk
	logic signed [EW-1:0]   e2;
	logic signed [EW-1:0]   ndy_w;
	logic signed [EW-1:0]   dx_w;
	logic                   x_go;
	logic                   y_go;
	logic signed [BW-1:0]   err_d;
	logic signed [BW-1:0]   cx_e;
	logic signed [BW-1:0]   cy_e;
	logic                   in_win;
	logic                   at_end;

	always_comb begin
		diff_x = {req_q.end_x[C-1], req_q.end_x} - {req_q.start_x[C-1], req_q.start_x};
		diff_y = {req_q.end_y[C-1], req_q.end_y} - {req_q.start_y[C-1], req_q.start_y};
		adx    = diff_x[C] ? -diff_x : diff_x;
		ady    = diff_y[C] ? -diff_y : diff_y;
		wx_e   = {{2{req_q.window_x[C-1]}}, req_q.window_x};
		wy_e   = {{2{req_q.window_y[C-1]}}, req_q.window_y};
		ml_e   = {{(BW-MARGIN_BITS){1'b0}}, margin_low_q};
		mh_e   = {{(BW-MARGIN_BITS){1'b0}}, margin_high_q};
	end

	always_comb begin
		span = (dx_q > dy_q) ? dx_q : dy_q;
		dx_e = {2'b00, dx_q};
		dy_e = {2'b00, dy_q};
	end

	always_comb begin
		e2     = {err_q, 1'b0};
		ndy_w  = {ndy_q[BW-1], ndy_q};
		dx_w   = {3'b000, dx_q};
		x_go   = (e2 >= ndy_w);
		y_go   = (e2 <= dx_w);
		err_d  = err_q + (x_go ? ndy_q : '0) + (y_go ? dx_e : '0);
		cx_e   = {{2{cur_x_q[C-1]}}, cur_x_q};
		cy_e   = {{2{cur_y_q[C-1]}}, cur_y_q};
		in_win = (cx_e >= lo_x_q) && (cx_e <= hi_x_q)
			&& (cy_e >= lo_y_q) && (cy_e <= hi_y_q);
		at_end = (cur_x_q == req_q.end_x) && (cur_y_q == req_q.end_y);
	end

	assign sts.too_long = too_long_q;
	assign sts.at_end   = at_end;
	assign out_data     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_low_q  <= MARGIN_LOW_RST;
			margin_high_q <= MARGIN_HIGH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MARGIN_LOW) begin
				margin_low_q <= cfg_data;
			end
			if (cfg_index == CFG_MARGIN_HIGH) begin
				margin_high_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
		if (cmd.setup) begin
			dx_q   <= adx[C-1:0];
			dy_q   <= ady[C-1:0];
			// equal coordinates count as stepping down, as the error rule never moves them
			xneg_q <= diff_x[C] || (diff_x == '0);
			yneg_q <= diff_y[C] || (diff_y == '0);
			lo_x_q <= wx_e - ml_e;
			hi_x_q <= wx_e + mh_e;
			lo_y_q <= wy_e - ml_e;
			hi_y_q <= wy_e + mh_e;
		end
		if (cmd.check) begin
			too_long_q <= (span > SPAN_MAX);
			err_q      <= dx_e - dy_e;
			ndy_q      <= -dy_e;
			cur_x_q    <= req_q.start_x;
			cur_y_q    <= req_q.start_y;
		end
		if (cmd.emit) begin
			if (too_long_q) begin
				res_q.point_x    <= '0;
				res_q.point_y    <= '0;
				res_q.inside_res <= 1'b0;
				res_q.last       <= 1'b1;
				res_q.too_long   <= 1'b1;
			end else begin
				res_q.point_x    <= cur_x_q;
				res_q.point_y    <= cur_y_q;
				res_q.inside_res <= in_win;
				res_q.last       <= at_end;
				res_q.too_long   <= 1'b0;
				if (!at_end) begin
					err_q <= err_d;
					if (x_go) begin
						cur_x_q <= xneg_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
					end
					if (y_go) begin
						cur_y_q <= yneg_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_bresenham_line_window_filter.sv
// ---------------------------------------------------------------------------
// tb_bresenham_line_window_filter
// Self-checking bench for the line walker. Line requests are queued up front,
// predicted point by point when transferred, and every point leaving the
// block is matched in order against the predicted points. Margins change
// between phases while the block is idle; both sides idle in random bursts.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_bresenham_line_window_filter;

	import blwf_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int LONGEST       = MAX_POINTS_DEF;

	// indexes past the register list, written to check they are ignored
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {
		ACT_LINE,
		ACT_MARGIN,
		ACT_DRAIN
	} act_t;

	typedef struct {
		act_t                      act;
		req_t                      line;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [MARGIN_BITS-1:0]    val;
		bit                        quiet;
	} line_cmd_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	req_t                      in_data   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	res_t                      out_data;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [MARGIN_BITS-1:0]    cfg_data  = '0;

	line_cmd_t cmd_q[$];
	res_t      point_q[$];

	logic [MARGIN_BITS-1:0] mrg_low  = MARGIN_LOW_RST;
	logic [MARGIN_BITS-1:0] mrg_high = MARGIN_HIGH_RST;

	bit quiet_tx   = 1'b0;
	bit quiet_rx   = 1'b0;
	int gap_left   = 0;
	int stall_left = 0;
	int settle     = 0;
	int mismatches = 0;

	bresenham_line_window_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// walk one request and queue the points it must produce
	task automatic plot_line(input req_t r);
		int   sx, sy, ex, ey, wx, wy;
		int   lox, hix, loy, hiy;
		int   adx, ady, span, stx, sty;
		int   cx, cy, err, e2, n;
		bit   done;
		res_t p;
		sx  = r.start_x;
		sy  = r.start_y;
		ex  = r.end_x;
		ey  = r.end_y;
		wx  = r.window_x;
		wy  = r.window_y;
		lox = wx - int'(mrg_low);
		hix = wx + int'(mrg_high);
		loy = wy - int'(mrg_low);
		hiy = wy + int'(mrg_high);
		adx = (ex >= sx) ? ex - sx : sx - ex;
		ady = (ey >= sy) ? ey - sy : sy - ey;
		span = (adx > ady) ? adx : ady;
		stx = (sx < ex) ? 1 : -1;
		sty = (sy < ey) ? 1 : -1;
		if (span + 1 > LONGEST) begin
			p = '0;
			p.last     = 1'b1;
			p.too_long = 1'b1;
			point_q = {point_q, p};
			return;
		end
		cx   = sx;
		cy   = sy;
		err  = adx - ady;
		n    = 0;
		done = 1'b0;
		while (!done) begin
			done = (cx == ex && cy == ey) || n == LONGEST - 1;
			p.point_x    = cx[COORD_BITS-1:0];
			p.point_y    = cy[COORD_BITS-1:0];
			p.inside_res = cx >= lox && cx <= hix && cy >= loy && cy <= hiy;
			p.last       = done;
			p.too_long   = 1'b0;
			point_q = {point_q, p};
			n++;
			if (!done) begin
				e2 = 2 * err;
				if (e2 >= -ady) begin
					err -= ady;
					cx  += stx;
				end
				if (e2 <= adx) begin
					err += adx;
					cy  += sty;
				end
			end
		end
	endtask

	task automatic add_line(input int sx, sy, ex, ey, wx, wy);
		line_cmd_t c;
		c = '{act: ACT_LINE, line: '0, idx: '0, val: '0, quiet: quiet_tx};
		c.line.start_x  = sx[COORD_BITS-1:0];
		c.line.start_y  = sy[COORD_BITS-1:0];
		c.line.end_x    = ex[COORD_BITS-1:0];
		c.line.end_y    = ey[COORD_BITS-1:0];
		c.line.window_x = wx[COORD_BITS-1:0];
		c.line.window_y = wy[COORD_BITS-1:0];
		cmd_q = {cmd_q, c};
	endtask

	task automatic add_margin(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
		line_cmd_t c;
		c = '{act: ACT_MARGIN, line: '0, idx: idx, val: val[MARGIN_BITS-1:0],
			quiet: quiet_tx};
		cmd_q = {cmd_q, c};
	endtask

	task automatic add_drain();
		line_cmd_t c;
		c = '{act: ACT_DRAIN, line: '0, idx: '0, val: '0, quiet: quiet_tx};
		cmd_q = {cmd_q, c};
	endtask

	// mostly well-formed short lines near their window; some long, some junk
	task automatic add_random_line();
		int sx, sy, ex, ey, wx, wy, len, dx, dy, pick;
		pick = $urandom_range(0, 99);
		sx   = int'($urandom_range(0, 65535)) - 32768;
		sy   = int'($urandom_range(0, 65535)) - 32768;
		if (pick < 70)
			len = $urandom_range(0, 20);
		else if (pick < 88)
			len = $urandom_range(21, LONGEST - 1);
		else
			len = $urandom_range(LONGEST, 200);
		if ($urandom_range(0, 1)) begin
			dx = len;
			dy = $urandom_range(0, len);
		end else begin
			dx = $urandom_range(0, len);
			dy = len;
		end
		if ($urandom_range(0, 1))
			dx = -dx;
		if ($urandom_range(0, 1))
			dy = -dy;
		ex = sx + dx;
		ey = sy + dy;
		if (ex < -32768 || ex > 32767)
			ex = sx - dx;
		if (ey < -32768 || ey > 32767)
			ey = sy - dy;
		if (pick >= 96) begin
			ex = int'($urandom_range(0, 65535)) - 32768;
			ey = int'($urandom_range(0, 65535)) - 32768;
		end
		if ($urandom_range(0, 3) != 0) begin
			wx = sx + int'($urandom_range(0, 2 * len + 80)) - (len + 40);
			wy = sy + int'($urandom_range(0, 2 * len + 80)) - (len + 40);
			if (wx < -32768 || wx > 32767)
				wx = sx;
			if (wy < -32768 || wy > 32767)
				wy = sy;
		end else begin
			wx = int'($urandom_range(0, 65535)) - 32768;
			wy = int'($urandom_range(0, 65535)) - 32768;
		end
		add_line(sx, sy, ex, ey, wx, wy);
	endtask

	// request driver: one transfer at a time, margin writes only once drained
	always @(posedge clk) begin
		line_cmd_t c;
		logic      v_nxt;
		logic      we_nxt;
		req_t      d_nxt;
		if (arst_n) begin
			v_nxt  = in_valid;
			d_nxt  = in_data;
			we_nxt = 1'b0;
			if (in_valid && !in_stall) begin
				plot_line(in_data);
				v_nxt = 1'b0;
			end
			if (!v_nxt && cmd_q.size() > 0) begin
				c = cmd_q[0];
				if (gap_left > 0) begin
					gap_left--;
				end else if (c.act == ACT_LINE) begin
					d_nxt = c.line;
					v_nxt = 1'b1;
					quiet_rx <= c.quiet;
					void'(cmd_q.pop_front());
					if (!c.quiet && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 5);
				end else if (point_q.size() != 0) begin
					settle = 0;
				end else if (settle < SETTLE_CYCLES) begin
					settle++;
				end else begin
					if (c.act == ACT_MARGIN) begin
						we_nxt = 1'b1;
						cfg_index <= c.idx;
						cfg_data  <= c.val;
						if (c.idx == CFG_MARGIN_LOW)
							mrg_low = c.val;
						else if (c.idx == CFG_MARGIN_HIGH)
							mrg_high = c.val;
					end
					settle = 0;
					void'(cmd_q.pop_front());
				end
			end
			in_valid <= v_nxt;
			in_data  <= d_nxt;
			cfg_we   <= we_nxt;
		end
	end

	// point monitor and output back-pressure
	always @(posedge clk) begin
		res_t want;
		logic s_nxt;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (point_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected point x=%0d y=%0d in=%b last=%b long=%b",
						$time, out_data.point_x, out_data.point_y, out_data.inside_res,
						out_data.last, out_data.too_long);
				end else begin
					want = point_q.pop_front();
					if (out_data !== want) begin
						mismatches++;
						$display("%0t: exp %0d,%0d in=%b l=%b t=%b got %0d,%0d in=%b l=%b t=%b",
							$time, want.point_x, want.point_y, want.inside_res,
							want.last, want.too_long, out_data.point_x, out_data.point_y,
							out_data.inside_res, out_data.last, out_data.too_long);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				s_nxt = 1'b1;
			end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 4);
				s_nxt      = 1'b1;
			end else begin
				s_nxt = 1'b0;
			end
			out_stall <= s_nxt;
		end
	end

	initial begin
		int mlo [5];
		int mhi [5];
		int i;
		int ph;
		mlo = '{0, 255, 37, 8, 0};
		mhi = '{255, 0, 5, 24, 0};
		mlo[4] = $urandom_range(0, 255);
		mhi[4] = $urandom_range(0, 255);

		// reset margins: single points at the origin and at the corners of the coordinate range
		add_line(0, 0, 0, 0, 0, 0);
		add_line(-32768, -32768, -32768, -32768, -32768, -32768);
		add_line(32767, 32767, 32767, 32767, 32767, 32767);
		add_line(32767, 32767, 32767, 32767, -32768, -32768);
		// axis-aligned walks, the first starting just outside the window
		add_line(0, 0, 10, 0, 9, 0);
		add_line(5, 3, -5, 3, 0, 0);
		add_line(2, -4, 2, 6, 0, 0);
		add_line(-3, 7, -3, -7, 0, -10);
		// all eight octants and two diagonals
		add_line(0, 0, 7, 3, 2, 2);
		add_line(0, 0, 3, 7, 2, 2);
		add_line(0, 0, -7, 3, 2, 2);
		add_line(0, 0, -3, 7, 2, 2);
		add_line(0, 0, -7, -3, 2, 2);
		add_line(0, 0, -3, -7, 2, 2);
		add_line(0, 0, 7, -3, 2, 2);
		add_line(0, 0, 3, -7, 2, 2);
		add_line(0, 0, 5, 5, 0, 0);
		add_line(0, 0, -5, 5, 0, 0);
		// longest legal walks, then one point too many on each axis and a full-range line
		add_line(-32768, -32768, -32705, -32741, -32768, -32760);
		add_line(32704, 32767, 32767, 32747, 32767, 32767);
		add_line(100, 100, 164, 100, 100, 100);
		add_line(0, 0, 3, -64, 0, 0);
		add_line(-32768, 32767, 32767, -32768, 0, 0);

		// zero-width window; spare indexes must leave the margins alone
		add_margin(CFG_MARGIN_LOW, 0);
		add_margin(CFG_MARGIN_HIGH, 0);
		add_margin(CFG_SPARE_A, 255);
		add_margin(CFG_SPARE_B, 170);
		add_line(0, 0, 2, 0, 1, 0);
		add_line(-7, 9, -7, 9, -7, 9);
		add_drain();
		add_margin(CFG_MARGIN_LOW, 255);
		add_margin(CFG_MARGIN_HIGH, 255);
		add_line(0, 0, -63, 63, 0, 0);
		add_line(256, 0, 256, 0, 0, 0);
		add_line(255, -255, 255, -255, 0, 0);
		add_line(-32768, -32768, -32758, -32728, -32513, -32513);

		for (ph = 0; ph < 5; ph++) begin
			quiet_tx = 1'b0;
			add_margin(CFG_MARGIN_LOW, mlo[ph]);
			add_margin(CFG_MARGIN_HIGH, mhi[ph]);
			for (i = 0; i < 64; i++) begin
				quiet_tx = (ph == 4) || ((i / 12) % 4 == 3);
				add_random_line();
				if ($urandom_range(0, 49) == 0)
					add_drain();
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || in_valid || point_q.size() != 0)
			@(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
